@@ rtl/assert_macros.svh @@
// Assertion macros shared by the volume gradient RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/vsg_pkg.sv @@
// Types and constants shared by the volume gradient modules.
`timescale 1ns / 1ps
`default_nettype none
package vsg_pkg;

	// Item codes on the input channel.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Register map.
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_ROWS   = 2'd0;
	localparam logic [1:0] REG_COLS   = 2'd1;
	localparam logic [1:0] REG_SLICES = 2'd2;
	localparam logic [1:0] REG_INV    = 2'd3;

	// Depth of the queue between front and back.
	localparam int unsigned Q_DEPTH = 4;

	typedef struct packed {
		logic        op;
		logic [15:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] grad_row;
		logic signed [15:0] grad_col;
		logic signed [19:0] grad_slice;
		logic               last;
	} out_beat_t;

	// One shift of the window, with the boundary flags of the voxel it answers.
	typedef struct packed {
		logic [15:0] data;
		logic        emit;
		logic        last;
		logic        rlo;
		logic        rhi;
		logic        clo;
		logic        chi;
		logic        slo;
		logic        shi;
	} cmd_t;

	typedef enum logic {
		FE_RUN,
		FE_PUMP
	} fe_state_t;

endpackage
`default_nettype wire

@@ rtl/vsg_ram.sv @@
// Generic single-clock RAM with one write port and a registered read-first port.
`timescale 1ns / 1ps
`default_nettype none
module vsg_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/vsg_regs.sv @@
// Configuration registers and the derived volume geometry.
`timescale 1ns / 1ps
`default_nettype none
module vsg_regs #(
	parameter int unsigned MAX_ROWS   = 512,
	parameter int unsigned MAX_COLS   = 512,
	parameter int unsigned MAX_SLICES = 1024,
	localparam int unsigned RIW = $clog2(MAX_ROWS),
	localparam int unsigned CIW = $clog2(MAX_COLS),
	localparam int unsigned SIW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
	localparam int unsigned RAW = $clog2(MAX_ROWS - 1),
	localparam int unsigned SAW = $clog2(MAX_ROWS * (MAX_COLS - 2) - 1),
	localparam int unsigned LW  = $clog2(MAX_ROWS * MAX_COLS + MAX_ROWS + 2)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vsg_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic                             clear,
	output logic      [RIW-1:0]              rlast,
	output logic      [CIW-1:0]              clast,
	output logic      [SIW-1:0]              slast,
	output logic      [RAW-1:0]              rwrap,
	output logic      [SAW-1:0]              swrap,
	output logic      [LW-1:0]               lag,
	output logic      [15:0]                 inv
);
	import vsg_pkg::*;

	localparam int unsigned R0 = (MAX_ROWS < 512) ? MAX_ROWS : 512;
	localparam int unsigned C0 = (MAX_COLS < 512) ? MAX_COLS : 512;
	localparam int unsigned S0 = (MAX_SLICES < 1024) ? MAX_SLICES : 1024;

	function automatic logic [31:0] clampv(input logic [31:0] v, input logic [31:0] lo,
			input logic [31:0] hi);
		clampv = (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	logic [9:0]  num_rows_q;
	logic [9:0]  num_cols_q;
	logic [10:0] num_slices_q;
	logic [15:0] inv_q;
	logic [RIW-1:0] rlast_q;
	logic [CIW-1:0] clast_q;
	logic [SIW-1:0] slast_q;
	logic [RAW-1:0] rwrap_q;
	logic [SAW-1:0] swrap_q;
	logic [LW-1:0]  lag_q;

	logic        wr;
	logic [1:0]  idx;
	logic [31:0] r_sel;
	logic [31:0] c_sel;
	logic [31:0] s_new;
	logic [31:0] plane;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign clear  = wr && (idx != REG_INV);

	// New geometry: the written dimension replaces the stored one.
	always_comb begin
		r_sel = (wr && idx == REG_ROWS) ? clampv({22'd0, pwdata[9:0]}, 32'd3, 32'(MAX_ROWS))
			: 32'(rlast_q) + 32'd1;
		c_sel = (wr && idx == REG_COLS) ? clampv({22'd0, pwdata[9:0]}, 32'd3, 32'(MAX_COLS))
			: 32'(clast_q) + 32'd1;
		s_new = clampv({21'd0, pwdata[10:0]}, 32'd1, 32'(MAX_SLICES));
		plane = r_sel * c_sel;
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q   <= 10'd512;
			num_cols_q   <= 10'd512;
			num_slices_q <= 11'd1024;
			inv_q        <= 16'd4096;
			rlast_q      <= RIW'(R0 - 1);
			clast_q      <= CIW'(C0 - 1);
			slast_q      <= SIW'(S0 - 1);
			rwrap_q      <= RAW'(R0 - 2);
			swrap_q      <= SAW'(R0 * C0 - 2 * R0 - 2);
			lag_q        <= LW'(R0 * C0 + R0 + 1);
		end else if (wr) begin
			unique case (idx)
				REG_ROWS, REG_COLS: begin
					if (idx == REG_ROWS) begin
						num_rows_q <= pwdata[9:0];
					end else begin
						num_cols_q <= pwdata[9:0];
					end
					rlast_q <= RIW'(r_sel - 32'd1);
					clast_q <= CIW'(c_sel - 32'd1);
					rwrap_q <= RAW'(r_sel - 32'd2);
					swrap_q <= SAW'(plane - 32'd2 * r_sel - 32'd2);
					lag_q   <= LW'(plane + r_sel + 32'd1);
				end
				REG_SLICES: begin
					num_slices_q <= pwdata[10:0];
					slast_q      <= SIW'(s_new - 32'd1);
				end
				REG_INV: begin
					inv_q <= pwdata[15:0];
				end
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (idx)
			REG_ROWS:   prdata = {22'd0, num_rows_q};
			REG_COLS:   prdata = {22'd0, num_cols_q};
			REG_SLICES: prdata = {21'd0, num_slices_q};
			REG_INV:    prdata = {16'd0, inv_q};
		endcase
	end

	assign rlast = rlast_q;
	assign clast = clast_q;
	assign slast = slast_q;
	assign rwrap = rwrap_q;
	assign swrap = swrap_q;
	assign lag   = lag_q;
	assign inv   = inv_q;
endmodule
`default_nettype wire

@@ rtl/vsg_front.sv @@
// Front end: accepts voxel beats, tracks positions and issues window shifts.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vsg_front #(
	parameter int unsigned MAX_ROWS   = 512,
	parameter int unsigned MAX_COLS   = 512,
	parameter int unsigned MAX_SLICES = 1024,
	localparam int unsigned RIW = $clog2(MAX_ROWS),
	localparam int unsigned CIW = $clog2(MAX_COLS),
	localparam int unsigned SIW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
	localparam int unsigned LW  = $clog2(MAX_ROWS * MAX_COLS + MAX_ROWS + 2)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic [RIW-1:0]    rlast,
	input  wire logic [CIW-1:0]    clast,
	input  wire logic [SIW-1:0]    slast,
	input  wire logic [LW-1:0]     lag,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire vsg_pkg::in_beat_t in_beat,
	output logic                   push,
	output vsg_pkg::cmd_t          cmd,
	input  wire logic              q_full
);
	import vsg_pkg::*;

	fe_state_t state_q, state_d;
	logic [RIW-1:0] in_row_q, out_r_q;
	logic [CIW-1:0] in_col_q, out_c_q;
	logic [SIW-1:0] in_slc_q, out_s_q;
	logic           full_q;
	logic [LW-1:0]  lead_q;

	logic acc, is_sample, store, vol_end, emit_now, o_last;

	assign is_sample = (in_beat.op == OP_SAMPLE);
	assign acc       = in_valid && in_ready;
	assign store     = acc && is_sample && !full_q;
	assign vol_end   = (in_row_q == rlast) && (in_col_q == clast) && (in_slc_q == slast);
	assign emit_now  = (lead_q == lag);
	assign o_last    = (out_r_q == rlast) && (out_c_q == clast) && (out_s_q == slast);

	// Next state: pump extra shifts until the pending result is out.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_RUN: begin
				if (push && !emit_now && (full_q || vol_end)) begin
					state_d = FE_PUMP;
				end
			end
			FE_PUMP: begin
				if (push && emit_now) begin
					state_d = FE_RUN;
				end
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			FE_RUN: begin
				in_ready = !q_full;
				push     = acc && (full_q || is_sample);
			end
			FE_PUMP: begin
				push = !q_full;
			end
		endcase
	end

	// The shift command carries the boundary flags of the voxel it answers.
	always_comb begin
		cmd.data = store ? in_beat.sample : 16'd0;
		cmd.emit = emit_now;
		cmd.last = o_last;
		cmd.rlo  = (out_r_q == '0);
		cmd.rhi  = (out_r_q == rlast);
		cmd.clo  = (out_c_q == '0);
		cmd.chi  = (out_c_q == clast);
		cmd.slo  = (out_s_q == '0);
		cmd.shi  = (out_s_q == slast);
	end

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FE_RUN;
			in_row_q <= '0;
			in_col_q <= '0;
			in_slc_q <= '0;
			out_r_q  <= '0;
			out_c_q  <= '0;
			out_s_q  <= '0;
			full_q   <= 1'b0;
			lead_q   <= '0;
		end else if (clear || (push && emit_now && o_last)) begin
			state_q  <= FE_RUN;
			in_row_q <= '0;
			in_col_q <= '0;
			in_slc_q <= '0;
			out_r_q  <= '0;
			out_c_q  <= '0;
			out_s_q  <= '0;
			full_q   <= 1'b0;
			lead_q   <= '0;
		end else begin
			state_q <= state_d;
			if (store) begin
				if (in_row_q == rlast) begin
					in_row_q <= '0;
					if (in_col_q == clast) begin
						in_col_q <= '0;
						if (in_slc_q == slast) begin
							in_slc_q <= '0;
							full_q   <= 1'b1;
						end else begin
							in_slc_q <= in_slc_q + 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end else begin
					in_row_q <= in_row_q + 1'b1;
				end
			end
			if (push) begin
				if (emit_now) begin
					if (out_r_q == rlast) begin
						out_r_q <= '0;
						if (out_c_q == clast) begin
							out_c_q <= '0;
							out_s_q <= out_s_q + 1'b1;
						end else begin
							out_c_q <= out_c_q + 1'b1;
						end
					end else begin
						out_r_q <= out_r_q + 1'b1;
					end
				end else begin
					lead_q <= lead_q + 1'b1;
				end
			end
		end
	end

	`ASSERT_NEVER(a_lead_bound, clk, arst_n, lead_q > lag, "window lead passed the lag")
	`ASSERT_IMPL(a_full_aligned, clk, arst_n, full_q && state_q == FE_RUN, lead_q == lag, "drain out of step")
endmodule
`default_nettype wire

@@ rtl/vsg_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vsg_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vsg_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output vsg_pkg::cmd_t      dout,
	output logic               empty
);
	import vsg_pkg::*;

	localparam int unsigned PW = $clog2(Q_DEPTH);
	localparam int unsigned NW = $clog2(Q_DEPTH + 1);

	cmd_t          buf_q [Q_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = buf_q[rp_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= din;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full && !pop, "queue overflow")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "queue underflow")
endmodule
`default_nettype wire

@@ rtl/vsg_back.sv @@
// Back end: line and slice delays, the 3x3x3 window and the gradient pipeline.
`timescale 1ns / 1ps
`default_nettype none
module vsg_back #(
	parameter int unsigned MAX_ROWS = 512,
	parameter int unsigned MAX_COLS = 512,
	localparam int unsigned RD  = MAX_ROWS - 1,
	localparam int unsigned SD  = MAX_ROWS * (MAX_COLS - 2) - 1,
	localparam int unsigned RAW = $clog2(RD),
	localparam int unsigned SAW = $clog2(SD)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clear,
	input  wire logic [RAW-1:0] rwrap,
	input  wire logic [SAW-1:0] swrap,
	input  wire logic [15:0]    inv,
	input  wire vsg_pkg::cmd_t  cmd,
	input  wire logic           q_empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output vsg_pkg::out_beat_t  out_beat
);
	import vsg_pkg::*;

	logic           en;
	logic [RAW-1:0] rptr_q;
	logic [SAW-1:0] sptr_q;
	logic [15:0]    t0_q;
	logic [95:0]    row_rd;
	logic [31:0]    slc_rd;
	logic [15:0]    t    [9];
	logic [15:0]    d1_q [9];
	logic [15:0]    d2_q [9];
	cmd_t           wf_q;
	logic           vw_q, v1_q, v2_q, v3_q, v4_q, vo_q;

	logic signed [16:0] dif   [9];
	logic        [17:0] smo   [9];
	logic signed [16:0] dif_s1 [9];
	logic        [17:0] smo_s1 [9];
	logic               last_s1, last_s2, last_s3, last_s4;
	logic signed [18:0] dd_s2 [3];
	logic signed [18:0] sd_s2 [3];
	logic        [19:0] ss_s2 [3];
	logic signed [20:0] gr_s3, gc_s3, gs_s3;
	logic signed [15:0] gr_s4, gc_s4;
	logic signed [37:0] pr_s4;
	out_beat_t          res_q;

	assign en  = !vo_q || out_ready;
	assign pop = en && !q_empty;

	// Window taps: line m = j + 3k is the input delayed by j rows and k slices.
	assign t[0] = t0_q;
	assign t[1] = row_rd[15:0];
	assign t[2] = row_rd[31:16];
	assign t[3] = slc_rd[15:0];
	assign t[4] = row_rd[47:32];
	assign t[5] = row_rd[63:48];
	assign t[6] = slc_rd[31:16];
	assign t[7] = row_rd[79:64];
	assign t[8] = row_rd[95:80];

	// Six row delays share one RAM, two slice delays share another.
	vsg_ram #(.WIDTH(96), .DEPTH(RD)) u_row_ram (
		.clk   (clk),
		.we    (pop),
		.waddr (rptr_q),
		.wdata ({t[7], t[6], t[4], t[3], t[1], t[0]}),
		.re    (pop),
		.raddr (rptr_q),
		.rdata (row_rd)
	);

	vsg_ram #(.WIDTH(32), .DEPTH(SD)) u_slc_ram (
		.clk   (clk),
		.we    (pop),
		.waddr (sptr_q),
		.wdata ({t[5], t[2]}),
		.re    (pop),
		.raddr (sptr_q),
		.rdata (slc_rd)
	);

	// Delay pointers and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			sptr_q <= '0;
			vw_q   <= 1'b0;
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			v3_q   <= 1'b0;
			v4_q   <= 1'b0;
			vo_q   <= 1'b0;
		end else begin
			if (clear) begin
				rptr_q <= '0;
				sptr_q <= '0;
			end else if (pop) begin
				rptr_q <= (rptr_q == rwrap) ? '0 : rptr_q + 1'b1;
				sptr_q <= (sptr_q == swrap) ? '0 : sptr_q + 1'b1;
			end
			if (en) begin
				vw_q <= pop && cmd.emit;
				v1_q <= vw_q;
				v2_q <= v1_q;
				v3_q <= v2_q;
				v4_q <= v3_q;
				vo_q <= v4_q;
			end
		end
	end

	// Window shift.
	always_ff @(posedge clk) begin
		if (pop) begin
			t0_q <= cmd.data;
			wf_q <= cmd;
			for (int m = 0; m < 9; m++) begin
				d1_q[m] <= t[m];
				d2_q[m] <= d1_q[m];
			end
		end
	end

	// Along the row: difference and smoothing of each masked line.
	always_comb begin
		logic        lm;
		logic [15:0] a, b, c;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				lm = ((j == 0) && wf_q.chi) || ((j == 2) && wf_q.clo)
					|| ((k == 0) && wf_q.shi) || ((k == 2) && wf_q.slo);
				a = (lm || wf_q.rlo) ? 16'd0 : d2_q[3 * k + j];
				b = lm ? 16'd0 : d1_q[3 * k + j];
				c = (lm || wf_q.rhi) ? 16'd0 : t[3 * k + j];
				dif[3 * k + j] = {1'b0, c} - {1'b0, a};
				smo[3 * k + j] = {2'b0, a} + {1'b0, b, 1'b0} + {2'b0, c};
			end
		end
	end

	// Gradient pipeline, advancing together when the output can move.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 9; m++) begin
				dif_s1[m] <= dif[m];
				smo_s1[m] <= smo[m];
			end
			last_s1 <= wf_q.last;

			for (int k = 0; k < 3; k++) begin
				dd_s2[k] <= 19'(dif_s1[3 * k]) + (19'(dif_s1[3 * k + 1]) <<< 1)
					+ 19'(dif_s1[3 * k + 2]);
				ss_s2[k] <= 20'(smo_s1[3 * k]) + (20'(smo_s1[3 * k + 1]) << 1)
					+ 20'(smo_s1[3 * k + 2]);
				sd_s2[k] <= $signed(19'(smo_s1[3 * k])) - $signed(19'(smo_s1[3 * k + 2]));
			end
			last_s2 <= last_s1;

			gr_s3   <= 21'(dd_s2[0]) + (21'(dd_s2[1]) <<< 1) + 21'(dd_s2[2]);
			gc_s3   <= 21'(sd_s2[0]) + (21'(sd_s2[1]) <<< 1) + 21'(sd_s2[2]);
			gs_s3   <= $signed(21'(ss_s2[0])) - $signed(21'(ss_s2[2]));
			last_s3 <= last_s2;

			gr_s4   <= 16'(gr_s3 >>> 5);
			gc_s4   <= 16'(gc_s3 >>> 5);
			pr_s4   <= gs_s3 * $signed({1'b0, inv});
			last_s4 <= last_s3;

			res_q.grad_row   <= gr_s4;
			res_q.grad_col   <= gc_s4;
			res_q.grad_slice <= 20'(pr_s4 >>> 17);
			res_q.last       <= last_s4;
		end
	end

	assign out_valid = vo_q;
	assign out_beat  = res_q;
endmodule
`default_nettype wire

@@ rtl/volume_sobel_gradient_3d_top.sv @@
// Top level of the streaming 3x3x3 Sobel gradient block.
//
// Voxels enter on the voxel channel (valid/ready), row index fastest, then
// column, then slice. Each sample beat shifts a 27-tap window fed by two row
// delays per slice plane and two slice delays, held in block RAM. Results
// leave on the grad channel: row, column and scaled slice gradient plus a
// last flag on the final voxel of the volume.
// Throughput is one beat per cycle while voxel_ready stays high; a result
// follows the voxel that completes its neighborhood, one slice, one column
// and one row later in the stream, through the queue and gradient pipeline.
// At the end, send flush beats, one per pending result. When the volume is a
// single slice, the beat that completes it
// also triggers rows+2 internal window shifts, during which voxel_ready is low.
// A stall on grad_ready freezes the back pipeline; the command queue keeps
// accepting until it fills, then voxel_ready drops.
// Reset clears all positions and loads the register defaults; the delay RAMs
// need no clearing. Writing rows, columns or slices restarts the volume.
`timescale 1ns / 1ps
`default_nettype none
module volume_sobel_gradient_3d_top #(
	parameter int unsigned MAX_ROWS   = 512,
	parameter int unsigned MAX_COLS   = 512,
	parameter int unsigned MAX_SLICES = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vsg_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        voxel_valid,
	output logic                             voxel_ready,
	input  wire vsg_pkg::in_beat_t           voxel,
	output logic                             grad_valid,
	input  wire logic                        grad_ready,
	output vsg_pkg::out_beat_t               grad
);
	import vsg_pkg::*;

	localparam int unsigned RIW = $clog2(MAX_ROWS);
	localparam int unsigned CIW = $clog2(MAX_COLS);
	localparam int unsigned SIW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int unsigned RAW = $clog2(MAX_ROWS - 1);
	localparam int unsigned SAW = $clog2(MAX_ROWS * (MAX_COLS - 2) - 1);
	localparam int unsigned LW  = $clog2(MAX_ROWS * MAX_COLS + MAX_ROWS + 2);

	logic           clear;
	logic [RIW-1:0] rlast;
	logic [CIW-1:0] clast;
	logic [SIW-1:0] slast;
	logic [RAW-1:0] rwrap;
	logic [SAW-1:0] swrap;
	logic [LW-1:0]  lag;
	logic [15:0]    inv;
	logic           push, q_full, pop, q_empty;
	cmd_t           cmd_in, cmd_out;

	vsg_regs #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_SLICES(MAX_SLICES)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clear   (clear),
		.rlast   (rlast),
		.clast   (clast),
		.slast   (slast),
		.rwrap   (rwrap),
		.swrap   (swrap),
		.lag     (lag),
		.inv     (inv)
	);

	vsg_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_SLICES(MAX_SLICES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.rlast    (rlast),
		.clast    (clast),
		.slast    (slast),
		.lag      (lag),
		.in_valid (voxel_valid),
		.in_ready (voxel_ready),
		.in_beat  (voxel),
		.push     (push),
		.cmd      (cmd_in),
		.q_full   (q_full)
	);

	vsg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (q_full),
		.pop    (pop),
		.dout   (cmd_out),
		.empty  (q_empty)
	);

	vsg_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.rwrap     (rwrap),
		.swrap     (swrap),
		.inv       (inv),
		.cmd       (cmd_out),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (grad_valid),
		.out_ready (grad_ready),
		.out_beat  (grad)
	);
endmodule
`default_nettype wire
